// File: hdl/triangle_strip_list_decoder_defines.svh
// Assertion macros shared by the triangle strip list decoder modules.
`ifndef TRIANGLE_STRIP_LIST_DECODER_DEFINES_SVH
`define TRIANGLE_STRIP_LIST_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset
`define TSLD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never occurs outside reset
`define TSLD_NEVER(label, clk, rst, cond, msg) \
   `TSLD_ASSERT(label, clk, rst, !(cond), msg)
`else
`define TSLD_ASSERT(label, clk, rst, prop, msg)
`define TSLD_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// File: hdl/tsld_pkg.sv
// Package: types, constants and value helpers for the triangle strip list decoder.
`timescale 1ns / 1ps

package tsld_pkg;

   // Default index width, fixed port widths and queue depth
   localparam int INDEX_BITS_DEF = 32;
   localparam int VERT_BITS      = 32;
   localparam int VALUE_BITS     = 32;
   localparam int QUEUE_DEPTH    = 2;

   // Value type codes
   localparam logic [2:0] TYPE_S8  = 3'd0;
   localparam logic [2:0] TYPE_U8  = 3'd1;
   localparam logic [2:0] TYPE_S16 = 3'd2;
   localparam logic [2:0] TYPE_U16 = 3'd3;
   localparam logic [2:0] TYPE_S32 = 3'd4;
   localparam logic [2:0] TYPE_U32 = 3'd5;

   // Register indexes
   localparam logic [1:0] CSR_COUNT_FMT  = 2'd0;
   localparam logic [1:0] CSR_INDEX_TYPE = 2'd1;
   localparam logic [1:0] CSR_MSB_FIRST  = 2'd2;

   // Register reset values
   localparam logic [2:0] COUNT_FMT_RST  = TYPE_U8;
   localparam logic [2:0] INDEX_TYPE_RST = TYPE_S32;
   localparam logic       MSB_FIRST_RST  = 1'b0;

   // Token kinds passed from the front to the back
   localparam logic [1:0] KIND_COUNT   = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_INDEX   = 2'd2;

   typedef struct packed {
      logic [2:0] count_fmt;
      logic [2:0] index_type;
      logic       msb_first;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       done;
   } tok_ctrl_type;

   // Byte position of the last byte of a value of the given type
   function automatic logic [1:0] type_last_pos(input logic [2:0] vtype);
      logic [1:0] pos;
      unique case (vtype) inside
         TYPE_S8, TYPE_U8:   pos = 2'd0;
         TYPE_S16, TYPE_U16: pos = 2'd1;
         default:            pos = 2'd3;
      endcase
      return pos;
   endfunction

   // Mask the assembled bytes to the type and extend to full width
   function automatic logic [VALUE_BITS-1:0] extend_value(input logic [VALUE_BITS-1:0] raw,
                                                          input logic [2:0] vtype);
      logic [VALUE_BITS-1:0] v;
      unique case (vtype) inside
         TYPE_S8:  v = VALUE_BITS'(signed'(raw[7:0]));
         TYPE_U8:  v = VALUE_BITS'(raw[7:0]);
         TYPE_S16: v = VALUE_BITS'(signed'(raw[15:0]));
         TYPE_U16: v = VALUE_BITS'(raw[15:0]);
         default:  v = raw;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/triangle_strip_list_decoder.sv
// Top level of the triangle strip list decoder: registers, front, queue and back.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one byte of a binary strip list per transfer: a count, then that
//   many vertex indices, each of the configured type and byte order.
//   rsp_* carries one result per emitted triangle and one at the end of each list
//   (tri_valid and list_done tell which; both may be set together).
//   csr_* writes the count type (0), the index type (1) and the byte order (2);
//   write only while the block is idle.
// Timing:
//   One byte is taken each cycle while req_stall is low. The byte that completes
//   a value is classified at its transfer edge and queued; the back pops it into
//   the result register. Bytes that do not complete a value produce nothing.
// Reset:
//   Synchronous reset returns to reading a count, empties the two-entry queue,
//   clears the strip state and sets the registers to u8 count, s32 index,
//   little endian.
// Stall:
//   A stalled result holds in the output register; the queue keeps taking
//   values until it holds two, then req_stall rises until the output drains.

module triangle_strip_list_decoder #(
   parameter int INDEX_BITS = tsld_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [1:0]                           csr_index,
   input  logic [2:0]                           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_stream_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_a,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_b,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_c,
   output logic                                 rsp_tri_valid,
   output logic                                 rsp_list_done
);

   localparam int CTRL_W = $bits(tsld_pkg::tok_ctrl_type);
   localparam int TOK_W  = CTRL_W + INDEX_BITS;

   tsld_pkg::cfg_type      cfg_ff, cfg_in;
   tsld_pkg::tok_ctrl_type push_ctrl, pop_ctrl;
   logic [INDEX_BITS-1:0]  push_index, pop_index;
   logic [TOK_W-1:0]       pop_data;
   logic                   push, pop, q_full, q_valid;

   // Decode register writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tsld_pkg::CSR_COUNT_FMT:  cfg_in.count_fmt  = csr_wdata;
            tsld_pkg::CSR_INDEX_TYPE: cfg_in.index_type = csr_wdata;
            tsld_pkg::CSR_MSB_FIRST:  cfg_in.msb_first  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_fmt  <= tsld_pkg::COUNT_FMT_RST;
         cfg_ff.index_type <= tsld_pkg::INDEX_TYPE_RST;
         cfg_ff.msb_first  <= tsld_pkg::MSB_FIRST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsld_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .q_full          (q_full),
      .push            (push),
      .tok_ctrl        (push_ctrl),
      .tok_index       (push_index)
   );

   tsld_queue #(
      .WIDTH (TOK_W),
      .DEPTH (tsld_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctrl, push_index}),
      .full      (q_full),
      .pop       (pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   // Split the queued token
   assign pop_ctrl  = pop_data[TOK_W-1:INDEX_BITS];
   assign pop_index = pop_data[INDEX_BITS-1:0];

   tsld_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .pop           (pop),
      .tok_ctrl      (pop_ctrl),
      .tok_index     (pop_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vert_a    (rsp_vert_a),
      .rsp_vert_b    (rsp_vert_b),
      .rsp_vert_c    (rsp_vert_c),
      .rsp_tri_valid (rsp_tri_valid),
      .rsp_list_done (rsp_list_done)
   );

endmodule

// File: hdl/tsld_front.sv
// Front end: assembles bytes into values, tracks the list count and classifies each value.
`timescale 1ns / 1ps

module tsld_front #(
   parameter int INDEX_BITS = tsld_pkg::INDEX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tsld_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_stream_byte,
   input  logic                     q_full,
   output logic                     push,
   output tsld_pkg::tok_ctrl_type   tok_ctrl,
   output logic [INDEX_BITS-1:0]    tok_index
);

   localparam int VB = tsld_pkg::VALUE_BITS;

   logic          phase_ff, phase_in;
   logic [1:0]    byte_pos_ff, byte_pos_in;
   logic [VB-1:0] assembly_ff, assembly_in;
   logic [VB-1:0] remaining_ff, remaining_in;

   logic          accept;
   logic [2:0]    cur_type;
   logic [VB-1:0] merged;
   logic          complete;
   logic [VB-1:0] value;
   logic          last_index;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cur_type  = phase_ff ? cfg.index_type : cfg.count_fmt;

   // Merge the new byte in the byte order in force
   always_comb begin
      if (cfg.msb_first) begin
         merged = {assembly_ff[VB-9:0], req_stream_byte};
      end else begin
         merged = assembly_ff | (VB'(req_stream_byte) << {byte_pos_ff, 3'b000});
      end
   end

   assign complete   = byte_pos_ff >= tsld_pkg::type_last_pos(cur_type);
   assign value      = tsld_pkg::extend_value(merged, cur_type);
   assign last_index = remaining_ff == VB'(1);
   assign tok_index  = value[INDEX_BITS-1:0];
   assign push       = accept && complete;

   // Classify the completed value and advance the list count
   always_comb begin
      phase_in       = phase_ff;
      byte_pos_in    = byte_pos_ff;
      assembly_in    = assembly_ff;
      remaining_in   = remaining_ff;
      tok_ctrl.kind  = tsld_pkg::KIND_COUNT;
      tok_ctrl.done  = 1'b0;
      if (!phase_ff) begin
         tok_ctrl.done = value == '0;
      end else begin
         tok_ctrl.kind = (&tok_index) ? tsld_pkg::KIND_RESTART : tsld_pkg::KIND_INDEX;
         tok_ctrl.done = last_index;
      end
      if (accept) begin
         if (!complete) begin
            byte_pos_in = 2'(byte_pos_ff + 2'd1);
            assembly_in = merged;
         end else begin
            byte_pos_in = '0;
            assembly_in = '0;
            if (!phase_ff) begin
               remaining_in = value;
               phase_in     = value != '0;
            end else begin
               remaining_in = remaining_ff - VB'(1);
               phase_in     = !last_index;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         byte_pos_ff  <= '0;
         assembly_ff  <= '0;
         remaining_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         byte_pos_ff  <= byte_pos_in;
         assembly_ff  <= assembly_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// File: hdl/tsld_queue.sv
// Short token queue between the front and the back.
`timescale 1ns / 1ps
`include "triangle_strip_list_decoder_defines.svh"

module tsld_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tsld_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign valid    = cnt_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TSLD_NEVER(a_no_push_full, clock, reset, push && full, "queue written while full")
   `TSLD_NEVER(a_no_pop_empty, clock, reset, pop && !valid, "queue read while empty")
   `TSLD_ASSERT(a_cnt_up, clock, reset,
                (push && !pop) |=> cnt_ff == CNT_W'($past(cnt_ff) + 1'b1),
                "queue count lost a write")

endmodule

// File: hdl/tsld_back.sv
// Back end: strip assembly, degenerate triangle drop and the result register.
`timescale 1ns / 1ps
`include "triangle_strip_list_decoder_defines.svh"

module tsld_back #(
   parameter int INDEX_BITS = tsld_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   output logic                                 pop,
   input  tsld_pkg::tok_ctrl_type               tok_ctrl,
   input  logic [INDEX_BITS-1:0]                tok_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_a,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_b,
   output logic signed [tsld_pkg::VERT_BITS-1:0] rsp_vert_c,
   output logic                                 rsp_tri_valid,
   output logic                                 rsp_list_done
);

   localparam int VW = tsld_pkg::VERT_BITS;

   logic [INDEX_BITS-1:0] older_ff, older_in;
   logic [INDEX_BITS-1:0] newer_ff, newer_in;
   logic [1:0]            run_ff, run_in;
   logic                  odd_ff, odd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         vert_a_ff, vert_a_in;
   logic [VW-1:0]         vert_b_ff, vert_b_in;
   logic [VW-1:0]         vert_c_ff, vert_c_in;
   logic                  tri_ff, tri_in;
   logic                  done_ff, done_in;

   logic [INDEX_BITS-1:0] sel_a, sel_b;
   logic                  tri_hit;

   // Take a token whenever the result register is free or draining
   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // Swap the held pair on odd strip positions
   assign sel_a   = odd_ff ? newer_ff : older_ff;
   assign sel_b   = odd_ff ? older_ff : newer_ff;
   assign tri_hit = (tok_ctrl.kind == tsld_pkg::KIND_INDEX) && run_ff[1] &&
                    (sel_a != sel_b) && (sel_a != tok_index) && (sel_b != tok_index);

   // Update strip state from the popped token
   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      run_in   = run_ff;
      odd_in   = odd_ff;
      if (pop) begin
         unique case (tok_ctrl.kind)
            tsld_pkg::KIND_COUNT: begin
               older_in = '0;
               newer_in = '0;
               run_in   = '0;
               odd_in   = 1'b0;
            end
            tsld_pkg::KIND_RESTART: begin
               run_in = '0;
               odd_in = 1'b0;
            end
            tsld_pkg::KIND_INDEX: begin
               older_in = newer_ff;
               newer_in = tok_index;
               run_in   = run_ff[1] ? run_ff : 2'(run_ff + 2'd1);
               odd_in   = !odd_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Load, hold or drain the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      vert_a_in    = vert_a_ff;
      vert_b_in    = vert_b_ff;
      vert_c_in    = vert_c_ff;
      tri_in       = tri_ff;
      done_in      = done_ff;
      if (pop) begin
         rsp_valid_in = tri_hit || tok_ctrl.done;
         vert_a_in    = tri_hit ? VW'(signed'(sel_a)) : '0;
         vert_b_in    = tri_hit ? VW'(signed'(sel_b)) : '0;
         vert_c_in    = tri_hit ? VW'(signed'(tok_index)) : '0;
         tri_in       = tri_hit;
         done_in      = tok_ctrl.done;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff     <= '0;
         newer_ff     <= '0;
         run_ff       <= '0;
         odd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         run_ff       <= run_in;
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vert_a_ff <= vert_a_in;
      vert_b_ff <= vert_b_in;
      vert_c_ff <= vert_c_in;
      tri_ff    <= tri_in;
      done_ff   <= done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vert_a    = vert_a_ff;
   assign rsp_vert_b    = vert_b_ff;
   assign rsp_vert_c    = vert_c_ff;
   assign rsp_tri_valid = tri_ff;
   assign rsp_list_done = done_ff;

   `TSLD_ASSERT(a_rsp_has_cause, clock, reset, rsp_valid_ff |-> (tri_ff || done_ff),
                "result with neither triangle nor end of list")
   `TSLD_ASSERT(a_tri_distinct, clock, reset,
                (rsp_valid_ff && tri_ff) |-> (vert_a_ff != vert_b_ff &&
                vert_a_ff != vert_c_ff && vert_b_ff != vert_c_ff),
                "degenerate triangle emitted")
   `TSLD_ASSERT(a_count_clears, clock, reset,
                (pop && tok_ctrl.kind == tsld_pkg::KIND_COUNT) |=> (run_ff == 2'd0 && !odd_ff),
                "strip state not cleared on new list")

endmodule

// File: tb/strip_result_checker.sv
// Checker for the triangle strip list decoder: predicts each result from the byte stream and compares.
`timescale 1ns / 1ps

module strip_result_checker #(
   parameter int INDEX_BITS = tsld_pkg::INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [2:0]         csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_vert_a,
   input  logic signed [31:0] rsp_vert_b,
   input  logic signed [31:0] rsp_vert_c,
   input  logic               rsp_tri_valid,
   input  logic               rsp_list_done,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic [31:0] vert_a;
      logic [31:0] vert_b;
      logic [31:0] vert_c;
      logic        has_tri;
      logic        ends_list;
   } strip_result_type;

   localparam logic [31:0] RESTART_VERTEX = '1;

   // Register copies
   logic [2:0]    count_kind;
   logic [2:0]    index_kind;
   logic          msb_first;

   // Decoder state as predicted
   logic          in_index_phase;
   logic [1:0]    byte_slot;
   logic [31:0]   gathered;
   logic [31:0]   left_to_read;
   logic [31:0]   older_vtx;
   logic [31:0]   newer_vtx;
   logic [1:0]    strip_len;
   logic          flip;

   strip_result_type triangle_q[$];
   int               mismatches = 0;

   assign fail_count = mismatches;

   function automatic int kind_bytes(input logic [2:0] kind);
      case (kind) inside
         tsld_pkg::TYPE_S8, tsld_pkg::TYPE_U8:   return 1;
         tsld_pkg::TYPE_S16, tsld_pkg::TYPE_U16: return 2;
         default:                                return 4;
      endcase
   endfunction

   // Mask to the type width, then sign- or zero-extend
   function automatic logic [31:0] widen(input logic [31:0] raw, input logic [2:0] kind);
      case (kind)
         tsld_pkg::TYPE_S8:  return {{24{raw[7]}}, raw[7:0]};
         tsld_pkg::TYPE_U8:  return {24'd0, raw[7:0]};
         tsld_pkg::TYPE_S16: return {{16{raw[15]}}, raw[15:0]};
         tsld_pkg::TYPE_U16: return {16'd0, raw[15:0]};
         default:            return raw;
      endcase
   endfunction

   task automatic clear_decoder();
      count_kind     = tsld_pkg::COUNT_FMT_RST;
      index_kind     = tsld_pkg::INDEX_TYPE_RST;
      msb_first      = tsld_pkg::MSB_FIRST_RST;
      in_index_phase = 1'b0;
      byte_slot      = '0;
      gathered       = '0;
      left_to_read   = '0;
      older_vtx      = '0;
      newer_vtx      = '0;
      strip_len      = '0;
      flip           = 1'b0;
      triangle_q.delete();
   endtask

   // Advance the decoder by one byte and queue any result it causes
   task automatic predict_byte(input logic [7:0] b);
      logic [2:0]       kind;
      logic [31:0]      value;
      logic [31:0]      vtx;
      logic [31:0]      first;
      logic [31:0]      second;
      strip_result_type r;
      kind = in_index_phase ? index_kind : count_kind;
      if (msb_first) begin
         gathered = {gathered[23:0], b};
      end else begin
         gathered = gathered | (32'(b) << (8 * byte_slot));
      end
      if (int'(byte_slot) + 1 < kind_bytes(kind)) begin
         byte_slot = byte_slot + 2'd1;
         return;
      end
      value     = widen(gathered, kind);
      byte_slot = '0;
      gathered  = '0;
      r         = '{default: '0};
      if (!in_index_phase) begin
         // A completed count opens a fresh strip
         left_to_read = value;
         strip_len    = '0;
         flip         = 1'b0;
         older_vtx    = '0;
         newer_vtx    = '0;
         if (value == 32'd0) begin
            r.ends_list = 1'b1;
         end else begin
            in_index_phase = 1'b1;
         end
      end else begin
         vtx = 32'(signed'(value[INDEX_BITS-1:0]));
         if (vtx == RESTART_VERTEX) begin
            strip_len = '0;
            flip      = 1'b0;
         end else begin
            // Swap the two held vertices on odd strip positions; drop degenerate triangles
            if (strip_len == 2'd2) begin
               first  = flip ? newer_vtx : older_vtx;
               second = flip ? older_vtx : newer_vtx;
               if (first != second && first != vtx && second != vtx) begin
                  r.has_tri = 1'b1;
                  r.vert_a  = first;
                  r.vert_b  = second;
                  r.vert_c  = vtx;
               end
            end
            older_vtx = newer_vtx;
            newer_vtx = vtx;
            if (strip_len != 2'd2) strip_len = strip_len + 2'd1;
            flip = ~flip;
         end
         left_to_read = left_to_read - 32'd1;
         if (left_to_read == 32'd0) begin
            r.ends_list    = 1'b1;
            in_index_phase = 1'b0;
         end
      end
      if (r.has_tri || r.ends_list) triangle_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch: got %0d, expected %0d",
               $realtime, what, $signed(got), $signed(want));
      mismatches++;
   endtask

   task automatic check_result();
      strip_result_type want;
      if (triangle_q.size() == 0) begin
         report_mismatch("surplus result", 32'd1, 32'd0);
         return;
      end
      want = triangle_q.pop_front();
      if (rsp_vert_a !== want.vert_a) report_mismatch("vert_a", rsp_vert_a, want.vert_a);
      if (rsp_vert_b !== want.vert_b) report_mismatch("vert_b", rsp_vert_b, want.vert_b);
      if (rsp_vert_c !== want.vert_c) report_mismatch("vert_c", rsp_vert_c, want.vert_c);
      if (rsp_tri_valid !== want.has_tri)
         report_mismatch("tri_valid", 32'(rsp_tri_valid), 32'(want.has_tri));
      if (rsp_list_done !== want.ends_list)
         report_mismatch("list_done", 32'(rsp_list_done), 32'(want.ends_list));
   endtask

   // Watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) predict_byte(req_stream_byte);
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_write_en) begin
            case (csr_index)
               tsld_pkg::CSR_COUNT_FMT:  count_kind = csr_wdata;
               tsld_pkg::CSR_INDEX_TYPE: index_kind = csr_wdata;
               tsld_pkg::CSR_MSB_FIRST:  msb_first  = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending = triangle_q.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the triangle strip list decoder: byte stream stimulus, register writes, verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int STREAM_BYTES = 1950;
   localparam int IDLE_LIMIT   = 1000;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               csr_write_en    = 1'b0;
   logic [1:0]         csr_index       = tsld_pkg::CSR_COUNT_FMT;
   logic [2:0]         csr_wdata       = '0;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [7:0]         req_stream_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic signed [31:0] rsp_vert_a;
   logic signed [31:0] rsp_vert_b;
   logic signed [31:0] rsp_vert_c;
   logic               rsp_tri_valid;
   logic               rsp_list_done;

   int                 fail_count;
   int                 pending;
   int                 bytes_sent   = 0;
   int                 quiet_cycles = 0;
   logic               calm         = 1'b0;

   // Format in force, used to encode the stream
   logic [2:0]         count_kind = tsld_pkg::COUNT_FMT_RST;
   logic [2:0]         index_kind = tsld_pkg::INDEX_TYPE_RST;
   logic               msb_first  = tsld_pkg::MSB_FIRST_RST;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   triangle_strip_list_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vert_a      (rsp_vert_a),
      .rsp_vert_b      (rsp_vert_b),
      .rsp_vert_c      (rsp_vert_c),
      .rsp_tri_valid   (rsp_tri_valid),
      .rsp_list_done   (rsp_list_done)
   );

   strip_result_checker strip_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vert_a      (rsp_vert_a),
      .rsp_vert_b      (rsp_vert_b),
      .rsp_vert_c      (rsp_vert_c),
      .rsp_tri_valid   (rsp_tri_valid),
      .rsp_list_done   (rsp_list_done),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   function automatic int kind_bytes(input logic [2:0] kind);
      case (kind) inside
         tsld_pkg::TYPE_S8, tsld_pkg::TYPE_U8:   return 1;
         tsld_pkg::TYPE_S16, tsld_pkg::TYPE_U16: return 2;
         default:                                return 4;
      endcase
   endfunction

   // Mostly small vertex numbers so that repeats occur; some restarts, edges and noise
   function automatic logic [31:0] pick_vertex(input bit wild);
      int          roll;
      logic [31:0] bit_edge;
      roll = $urandom_range(0, 99);
      if (wild || roll < 8) return $urandom();
      if (roll < 16) return '1;
      if (roll < 24) begin
         bit_edge = 32'd1 << $urandom_range(0, 31);
         return (roll < 20) ? bit_edge : bit_edge - 32'd1;
      end
      return $urandom_range(0, 7);
   endfunction

   // Offer one byte after a random gap and hold it until the transfer
   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic send_value(input logic [31:0] v, input logic [2:0] kind);
      int n;
      n = kind_bytes(kind);
      for (int k = 0; k < n; k++) push_byte(8'(v >> (8 * (msb_first ? n - 1 - k : k))));
   endtask

   task automatic send_list(input int n, input bit wild);
      send_value(32'(n), count_kind);
      repeat (n) send_value(pick_vertex(wild), index_kind);
   endtask

   // Hold the sender until every predicted result has been taken, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_format(input logic [2:0] ct, input logic [2:0] it, input logic be);
      settle();
      write_reg(tsld_pkg::CSR_COUNT_FMT, ct);
      write_reg(tsld_pkg::CSR_INDEX_TYPE, it);
      write_reg(tsld_pkg::CSR_MSB_FIRST, {2'b00, be});
      count_kind = ct;
      index_kind = it;
      msb_first  = be;
   endtask

   // Result side: stall for a random gap before each transfer, unless calm
   always begin : result_drain
      int hold;
      hold = calm ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(negedge clock);
      end
      rsp_stall <= 1'b0;
      do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("triangle_strip_list_decoder test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int lists;
      int n;
      bit wild;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Empty list: done on its count byte
      set_format(tsld_pkg::TYPE_U8, tsld_pkg::TYPE_S8, 1'b0);
      push_byte(8'd0);

      // Strip with an odd-position swap, a degenerate triangle, a restart, extremes,
      // and a triangle on the closing index
      send_value(32'd9, count_kind);
      send_value(32'd5, index_kind);
      send_value(32'd6, index_kind);
      send_value(32'd7, index_kind);
      send_value(32'd8, index_kind);
      send_value(32'd8, index_kind);
      send_value(32'hFF, index_kind);
      send_value(32'h7F, index_kind);
      send_value(32'h80, index_kind);
      send_value(32'd0, index_kind);

      // Big-endian 32-bit unsigned indices at the signed limits
      set_format(tsld_pkg::TYPE_S16, tsld_pkg::TYPE_U32, 1'b1);
      send_value(32'd3, count_kind);
      send_value(32'h7FFF_FFFF, index_kind);
      send_value(32'h8000_0000, index_kind);
      send_value(32'h0000_0001, index_kind);

      // Narrow the count type part-way through a value
      settle();
      write_reg(tsld_pkg::CSR_COUNT_FMT, tsld_pkg::TYPE_U32);
      count_kind = tsld_pkg::TYPE_U32;
      push_byte(8'h00);
      push_byte(8'h00);
      set_format(tsld_pkg::TYPE_U8, tsld_pkg::TYPE_S16, 1'b0);
      push_byte(8'h02);
      send_list(4, 1'b0);

      // Random formats, lists of random length and content
      while (bytes_sent < STREAM_BYTES) begin
         set_format(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
         calm  = ($urandom_range(0, 3) == 0);
         lists = $urandom_range(1, 4);
         repeat (lists) begin
            case ($urandom_range(0, 9))
               0:       n = $urandom_range(0, 2);
               default: n = $urandom_range(3, 24);
            endcase
            wild = ($urandom_range(0, 9) == 0);
            send_list(n, wild);
         end
      end

      // Negative signed count: the list runs on past the end of the test
      set_format(tsld_pkg::TYPE_S8, tsld_pkg::TYPE_U8, 1'b0);
      calm = 1'b0;
      push_byte(8'hFE);
      repeat (40) send_value(pick_vertex(1'b0), index_kind);

      settle();
      if (fail_count == 0) begin
         $display("triangle_strip_list_decoder test passed");
      end else begin
         $display("triangle_strip_list_decoder test failed");
      end
      $finish;
   end

endmodule
